// ===== rtl/gwmf_pkg.sv =====
`timescale 1ns / 1ps

package gwmf_pkg;

    localparam int MAX_COLS_DEF   = 1024;
    localparam int MAX_HALF_W_DEF = 3;
    localparam int MAX_HALF_H_DEF = 3;
    localparam int ROW_LIMIT      = 4096;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int POS_W   = 26;
    localparam int COLS_W  = 13;
    localparam int ROW_W   = 13;

    localparam logic [10:0] COLS_RESET = 11'd640;
    localparam logic [12:0] ROWS_RESET = 13'd480;
    localparam logic [1:0]  HALF_RESET = 2'd1;

    typedef enum logic [1:0] {
        CFG_IMAGE_COLS,
        CFG_IMAGE_ROWS,
        CFG_HALF_WIDTH,
        CFG_HALF_HEIGHT
    } cfg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             border;
        logic             last;
        logic [PIX_W-1:0] center;
    } side_t;

endpackage

// ===== rtl/grayscale_window_median_filter_unit.sv =====
`timescale 1ns / 1ps
// Path: each pixel passes the line read, window shift and eight bit cells to m_tdata; results
// begin once the raster delay of hh*cols+hw pixels has been taken.
// Throughput: one pixel or flush per cycle while m_tready allows; a flush on an image smaller
// than the window holds s_tready low while the line chain advances up to the pending output.
// Reset: synchronous active-low; clears counters and pipeline valids, loads default geometry.
module grayscale_window_median_filter_unit #(
    parameter int MAX_COLS   = gwmf_pkg::MAX_COLS_DEF,
    parameter int MAX_HALF_W = gwmf_pkg::MAX_HALF_W_DEF,
    parameter int MAX_HALF_H = gwmf_pkg::MAX_HALF_H_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] pixel_in
    input  logic                       s_tuser,   // [0] flush
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] pixel_out
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [gwmf_pkg::CFG_W-1:0] cfg_data
);

    localparam int NC     = 2 * MAX_HALF_W + 1;
    localparam int NR     = 2 * MAX_HALF_H + 1;
    localparam int WIN_N  = NC * NR;
    localparam int RK_W   = $clog2(WIN_N + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int HW_W   = $clog2(MAX_HALF_W + 1);
    localparam int HH_W   = $clog2(MAX_HALF_H + 1);
    localparam int POS_W  = gwmf_pkg::POS_W;
    localparam int COLS_W = gwmf_pkg::COLS_W;
    localparam int ROW_W  = gwmf_pkg::ROW_W;
    localparam int PW     = gwmf_pkg::PIX_W;

    logic [10:0] cols_cfg_reg;
    logic [12:0] rows_cfg_reg;
    logic [1:0]  hw_cfg_reg, hh_cfg_reg;

    logic [COLS_W-1:0] cols_e;
    logic [ROW_W-1:0]  rows_e;
    logic [HW_W-1:0]   hw_e;
    logic [HH_W-1:0]   hh_e;
    logic [POS_W-1:0]  total, delay;
    logic [RK_W-1:0]   rank0;

    logic [POS_W-1:0] pin_reg, pin_next, pout_reg, pout_next;
    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             busy_reg, busy_next;

    logic            adv, push, emit, in_done, out_left, last, border;
    logic [PW-1:0]   push_pix;
    gwmf_pkg::side_t side_f, side_b;
    logic [PW-1:0]   win [WIN_N];

    logic [PW-1:0]   vals_c [9][WIN_N];
    logic [WIN_N-1:0] act_c [9];
    logic [RK_W-1:0] rank_c [9];
    logic [PW-1:0]   res_c [9];
    gwmf_pkg::side_t side_c [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= gwmf_pkg::COLS_RESET;
            rows_cfg_reg <= gwmf_pkg::ROWS_RESET;
            hw_cfg_reg   <= gwmf_pkg::HALF_RESET;
            hh_cfg_reg   <= gwmf_pkg::HALF_RESET;
        end else if (cfg_we) begin
            unique case (gwmf_pkg::cfg_idx_t'(cfg_index))
                gwmf_pkg::CFG_IMAGE_COLS:  cols_cfg_reg <= cfg_data[10:0];
                gwmf_pkg::CFG_IMAGE_ROWS:  rows_cfg_reg <= cfg_data[12:0];
                gwmf_pkg::CFG_HALF_WIDTH:  hw_cfg_reg   <= cfg_data[1:0];
                gwmf_pkg::CFG_HALF_HEIGHT: hh_cfg_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_e = COLS_W'(1);
        end else if (COLS_W'(cols_cfg_reg) > COLS_W'(MAX_COLS)) begin
            cols_e = COLS_W'(MAX_COLS);
        end else begin
            cols_e = COLS_W'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_e = ROW_W'(1);
        end else if (rows_cfg_reg > ROW_W'(gwmf_pkg::ROW_LIMIT)) begin
            rows_e = ROW_W'(gwmf_pkg::ROW_LIMIT);
        end else begin
            rows_e = rows_cfg_reg;
        end
        hw_e  = (int'(hw_cfg_reg) > MAX_HALF_W) ? HW_W'(MAX_HALF_W) : HW_W'(hw_cfg_reg);
        hh_e  = (int'(hh_cfg_reg) > MAX_HALF_H) ? HH_W'(MAX_HALF_H) : HH_W'(hh_cfg_reg);
        total = POS_W'(rows_e) * POS_W'(cols_e);
        delay = POS_W'(hh_e) * POS_W'(cols_e) + POS_W'(hw_e);
        rank0 = RK_W'(((2 * int'(hw_e) + 1) * (2 * int'(hh_e) + 1) - 1) / 2);
    end

    assign adv      = !m_tvalid | m_tready;
    assign s_tready = adv & !busy_reg;
    assign in_done  = (pin_reg >= total);
    assign out_left = (pout_reg < total);

    always_comb begin
        if (busy_reg) begin
            push = adv;
        end else begin
            push = s_tvalid & s_tready &
                   ((s_tuser & in_done & out_left) | (!s_tuser & !in_done));
        end
        emit     = push & (pin_reg >= delay);
        push_pix = (busy_reg | s_tuser) ? '0 : s_tdata;
        last     = ((pout_reg + POS_W'(1)) == total);
        border   = (out_row_reg < ROW_W'(hh_e)) |
                   ((out_row_reg + ROW_W'(hh_e)) >= rows_e) |
                   (COLS_W'(out_col_reg) < COLS_W'(hw_e)) |
                   ((COLS_W'(out_col_reg) + COLS_W'(hw_e)) >= cols_e);
        side_f.valid  = emit;
        side_f.border = border;
        side_f.last   = last;
        side_f.center = '0;
    end

    always_comb begin
        pin_next     = pin_reg;
        pout_next    = pout_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        busy_next    = busy_reg;
        if (cfg_we) begin
            pin_next     = '0;
            pout_next    = '0;
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            busy_next    = 1'b0;
        end else if (push) begin
            pin_next = pin_reg + POS_W'(1);
            if ((COLS_W'(in_col_reg) + COLS_W'(1)) >= cols_e) begin
                in_col_next = '0;
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            busy_next = emit ? 1'b0 : (busy_reg | s_tuser);
            if (emit) begin
                pout_next = pout_reg + POS_W'(1);
                if ((COLS_W'(out_col_reg) + COLS_W'(1)) >= cols_e) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                if (last) begin
                    pin_next     = '0;
                    pout_next    = '0;
                    in_col_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    busy_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg     <= '0;
            pout_reg    <= '0;
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            busy_reg    <= 1'b0;
        end else begin
            pin_reg     <= pin_next;
            pout_reg    <= pout_next;
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            busy_reg    <= busy_next;
        end
    end

    gwmf_window #(
        .MAX_COLS   (MAX_COLS),
        .MAX_HALF_W (MAX_HALF_W),
        .MAX_HALF_H (MAX_HALF_H),
        .COL_W      (COL_W),
        .NC         (NC),
        .NR         (NR)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .push     (push),
        .col      (in_col_reg),
        .pix      (push_pix),
        .side_in  (side_f),
        .win      (win),
        .side_out (side_b)
    );

    always_comb begin
        vals_c[0] = win;
        for (int c = 0; c < NC; c++) begin
            for (int r = 0; r < NR; r++) begin
                act_c[0][c*NR+r] = (c <= 2 * int'(hw_e)) && (r <= 2 * int'(hh_e));
            end
        end
        rank_c[0]        = rank0;
        res_c[0]         = '0;
        side_c[0]        = side_b;
        side_c[0].center = win[int'(hw_e) * NR + int'(hh_e)];
    end

    for (genvar b = 0; b < PW; b++) begin : g_cell
        gwmf_median_cell #(
            .WIN_N (WIN_N),
            .RK_W  (RK_W),
            .BIT   (PW - 1 - b)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .vals_in  (vals_c[b]),
            .act_in   (act_c[b]),
            .rank_in  (rank_c[b]),
            .res_in   (res_c[b]),
            .side_in  (side_c[b]),
            .vals_out (vals_c[b+1]),
            .act_out  (act_c[b+1]),
            .rank_out (rank_c[b+1]),
            .res_out  (res_c[b+1]),
            .side_out (side_c[b+1])
        );
    end

    assign m_tvalid = side_c[PW].valid;
    assign m_tdata  = side_c[PW].border ? side_c[PW].center : res_c[PW];
    assign m_tlast  = side_c[PW].last;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input taken during catch-up");

    a_busy_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> in_done)
        else $error("catch-up before frame input complete");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last && !cfg_we) |=> (pin_reg == '0) && (pout_reg == '0) && !busy_reg)
        else $error("counters not cleared at frame end");

    a_emit_needs_push: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> push && adv)
        else $error("result without advance");

endmodule

// ===== rtl/gwmf_ram.sv =====
`timescale 1ns / 1ps

module gwmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gwmf_window.sv =====
`timescale 1ns / 1ps

module gwmf_window #(
    parameter int MAX_COLS   = gwmf_pkg::MAX_COLS_DEF,
    parameter int MAX_HALF_W = gwmf_pkg::MAX_HALF_W_DEF,
    parameter int MAX_HALF_H = gwmf_pkg::MAX_HALF_H_DEF,
    parameter int COL_W      = $clog2(MAX_COLS),
    parameter int NC         = 2 * MAX_HALF_W + 1,
    parameter int NR         = 2 * MAX_HALF_H + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          push,
    input  logic [COL_W-1:0]              col,
    input  logic [gwmf_pkg::PIX_W-1:0]    pix,
    input  gwmf_pkg::side_t               side_in,
    output logic [gwmf_pkg::PIX_W-1:0]    win [NC*NR],
    output gwmf_pkg::side_t               side_out
);

    localparam int NL = 2 * MAX_HALF_H;

    logic                       a_push_reg, a_push_next;
    logic [COL_W-1:0]           a_col_reg;
    logic [gwmf_pkg::PIX_W-1:0] a_pix_reg;
    gwmf_pkg::side_t            a_side_reg, b_side_reg;
    logic                       byp_reg;
    logic [gwmf_pkg::PIX_W-1:0] byp_data_reg [NL];
    logic [gwmf_pkg::PIX_W-1:0] win_reg [NC][NR];
    logic [gwmf_pkg::PIX_W-1:0] rdata [NL];
    logic [gwmf_pkg::PIX_W-1:0] colv [NR];

    assign a_push_next = push;

    always_comb begin
        colv[0] = a_pix_reg;
        for (int k = 0; k < NL; k++) begin
            colv[k+1] = byp_reg ? byp_data_reg[k] : rdata[k];
        end
    end

    for (genvar k = 0; k < NL; k++) begin : g_line
        gwmf_ram #(
            .WIDTH (gwmf_pkg::PIX_W),
            .DEPTH (MAX_COLS),
            .AW    (COL_W)
        ) u_line (
            .aclk  (aclk),
            .we    (adv & a_push_reg),
            .waddr (a_col_reg),
            .wdata (colv[k]),
            .re    (adv),
            .raddr (col),
            .rdata (rdata[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_push_reg <= 1'b0;
            a_side_reg <= '0;
            b_side_reg <= '0;
            byp_reg    <= 1'b0;
        end else if (adv) begin
            a_push_reg       <= a_push_next;
            a_side_reg       <= side_in;
            b_side_reg       <= a_side_reg;
            byp_reg          <= push & a_push_reg & (col == a_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_col_reg <= col;
            a_pix_reg <= pix;
            for (int k = 0; k < NL; k++) begin
                byp_data_reg[k] <= colv[k];
            end
            if (a_push_reg) begin
                win_reg[0] <= colv;
                for (int c = 1; c < NC; c++) begin
                    win_reg[c] <= win_reg[c-1];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            for (int r = 0; r < NR; r++) begin
                win[c*NR+r] = win_reg[c][r];
            end
        end
    end

    assign side_out = b_side_reg;

endmodule

// ===== rtl/gwmf_median_cell.sv =====
`timescale 1ns / 1ps

module gwmf_median_cell #(
    parameter int WIN_N = 49,
    parameter int RK_W  = 6,
    parameter int BIT   = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic [gwmf_pkg::PIX_W-1:0] vals_in [WIN_N],
    input  logic [WIN_N-1:0]           act_in,
    input  logic [RK_W-1:0]            rank_in,
    input  logic [gwmf_pkg::PIX_W-1:0] res_in,
    input  gwmf_pkg::side_t            side_in,
    output logic [gwmf_pkg::PIX_W-1:0] vals_out [WIN_N],
    output logic [WIN_N-1:0]           act_out,
    output logic [RK_W-1:0]            rank_out,
    output logic [gwmf_pkg::PIX_W-1:0] res_out,
    output gwmf_pkg::side_t            side_out
);

    logic [gwmf_pkg::PIX_W-1:0] vals_reg [WIN_N];
    logic [WIN_N-1:0]           act_reg, act_next;
    logic [RK_W-1:0]            rank_reg, rank_next;
    logic [gwmf_pkg::PIX_W-1:0] res_reg, res_next;
    gwmf_pkg::side_t            side_reg;
    logic [RK_W-1:0]            zeros;
    logic                       one;

    always_comb begin
        zeros = '0;
        for (int i = 0; i < WIN_N; i++) begin
            zeros = zeros + RK_W'(act_in[i] & ~vals_in[i][BIT]);
        end
        one       = (rank_in >= zeros);
        res_next  = res_in;
        res_next[BIT] = one;
        rank_next = one ? (rank_in - zeros) : rank_in;
        for (int i = 0; i < WIN_N; i++) begin
            act_next[i] = act_in[i] & (vals_in[i][BIT] == one);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (adv) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vals_reg <= vals_in;
            act_reg  <= act_next;
            rank_reg <= rank_next;
            res_reg  <= res_next;
        end
    end

    assign vals_out = vals_reg;
    assign act_out  = act_reg;
    assign rank_out = rank_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule
